[hw/rtl/jic_pkg.sv]
// Shared types and constants for the joystick input conditioner.
package jic_pkg;

    localparam int AXIS_W        = 10;
    localparam int AXIS_FIELDS   = 6;
    localparam int BASE_AXES     = 3;
    localparam int SWITCH_FIELDS = 16;
    localparam int TIME_W        = 32;
    localparam int DEBOUNCE_W    = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NC_MASK       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIX_AXIS_MODE = 2'd2;

    localparam logic [DEBOUNCE_W-1:0]    DEBOUNCE_RESET = 16'd10;
    localparam logic [SWITCH_FIELDS-1:0] NC_MASK_RESET  = 16'hC0C0;
    localparam logic                     SIX_AXIS_RESET = 1'b1;

    typedef struct packed {
        logic [AXIS_W-1:0]        sample_throttle;
        logic [AXIS_W-1:0]        sample_propeller;
        logic [AXIS_W-1:0]        sample_trim;
        logic [AXIS_W-1:0]        sample_rudder;
        logic [AXIS_W-1:0]        sample_x;
        logic [AXIS_W-1:0]        sample_y;
        logic [SWITCH_FIELDS-1:0] switch_levels;
        logic [TIME_W-1:0]        now_ms;
    } t_in_word;

    typedef struct packed {
        logic [AXIS_W-1:0]        out_throttle;
        logic [AXIS_W-1:0]        out_propeller;
        logic [AXIS_W-1:0]        out_trim;
        logic [AXIS_W-1:0]        out_rudder;
        logic [AXIS_W-1:0]        out_x;
        logic [AXIS_W-1:0]        out_y;
        logic [SWITCH_FIELDS-1:0] button_word;
    } t_out_word;

    // per-scan control shared by the axis and switch units
    typedef struct packed {
        logic advance;
        logic six;
    } t_scan_ctl;

endpackage

[hw/rtl/jic_axis_filter.sv]
// Two-tap axis averaging with optional inversion and per-axis history.
module jic_axis_filter #(
    parameter int NUM_AXES = 6
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  jic_pkg::t_scan_ctl                                  i_ctl,
    input  logic [jic_pkg::AXIS_FIELDS-1:0][jic_pkg::AXIS_W-1:0] i_samples,
    output logic [jic_pkg::AXIS_FIELDS-1:0][jic_pkg::AXIS_W-1:0] o_values
);

    localparam int NA = (NUM_AXES < jic_pkg::AXIS_FIELDS) ? NUM_AXES : jic_pkg::AXIS_FIELDS;

    for (genvar g = 0; g < jic_pkg::AXIS_FIELDS; g++) begin : g_axis
        if (g < NA) begin : g_used
            localparam bit ALWAYS_ON = (g < jic_pkg::BASE_AXES);
            logic [jic_pkg::AXIS_W-1:0] r_prev;
            logic [jic_pkg::AXIS_W:0]   sum;
            logic [jic_pkg::AXIS_W-1:0] avg;
            logic                       active;

            assign active = ALWAYS_ON || i_ctl.six;
            assign sum    = {1'b0, i_samples[g]} + {1'b0, r_prev};
            assign avg    = sum[jic_pkg::AXIS_W:1];
            // full-scale minus avg is the bitwise complement at this width
            assign o_values[g] = !active ? '0 : (i_ctl.six ? ~avg : avg);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_prev <= '0;
                end else if (i_ctl.advance && active) begin
                    r_prev <= i_samples[g];
                end
            end
        end else begin : g_unused
            assign o_values[g] = '0;
        end
    end

endmodule

[hw/rtl/jic_switch_debounce.sv]
// Lockout debounce for the switch inputs, normally-closed inversion and packing.
module jic_switch_debounce #(
    parameter int NUM_SWITCHES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  jic_pkg::t_scan_ctl                 i_ctl,
    input  logic [jic_pkg::SWITCH_FIELDS-1:0]  i_levels,
    input  logic [jic_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [jic_pkg::DEBOUNCE_W-1:0]     i_debounce_ms,
    input  logic [jic_pkg::SWITCH_FIELDS-1:0]  i_nc_mask,
    output logic [jic_pkg::SWITCH_FIELDS-1:0]  o_buttons
);

    // switch outputs past the reported ones are tied low and never change
    localparam int NSW = (NUM_SWITCHES < jic_pkg::SWITCH_FIELDS) ?
                         NUM_SWITCHES : jic_pkg::SWITCH_FIELDS;

    logic [jic_pkg::TIME_W-1:0] debounce_ext;
    assign debounce_ext = {{(jic_pkg::TIME_W-jic_pkg::DEBOUNCE_W){1'b0}}, i_debounce_ms};

    for (genvar g = 0; g < jic_pkg::SWITCH_FIELDS; g++) begin : g_sw
        if (g < NSW) begin : g_used
            logic                       r_state;
            logic [jic_pkg::TIME_W-1:0] r_start;
            logic                       n_state;
            logic [jic_pkg::TIME_W-1:0] n_start;
            logic [jic_pkg::TIME_W-1:0] elapsed;
            logic                       locked;

            assign elapsed = i_now_ms - r_start;
            // zero start means no lockout pending
            assign locked  = (r_start != '0) && (elapsed < debounce_ext);

            always_comb begin
                n_state = r_state;
                n_start = r_start;
                if (!locked) begin
                    n_start = '0;
                    if (r_state != i_levels[g]) begin
                        n_state = i_levels[g];
                        n_start = i_now_ms;
                    end
                end
            end

            assign o_buttons[g] = i_ctl.six & (n_state ^ i_nc_mask[g]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_state <= 1'b0;
                    r_start <= '0;
                end else if (i_ctl.advance && i_ctl.six) begin
                    r_state <= n_state;
                    r_start <= n_start;
                end
            end
        end else begin : g_unused
            assign o_buttons[g] = 1'b0;
        end
    end

endmodule

[hw/rtl/joystick_input_conditioner_core.sv]
// Top level of the joystick input conditioner: handshake, config registers, pipeline.
//
// Input channel: i_in_valid / o_in_stall carry one scan word (six axis samples,
// switch levels, millisecond time). Output channel: o_out_valid / i_out_stall
// carry one result word per scan (six filtered axes, packed button word).
// A word moves when valid is high and stall is low at a rising edge.
// Pipeline: input register, then axis filters and switch debounce in one
// combinational pass, then the result register, which drives o_out_valid.
// Throughput is one scan per cycle while the receiver does not stall, set by
// the single pass from input register to result register.
// Filter history (active axes) and debounce state (six-axis mode) update when a scan
// moves into the result register. Config (debounce_ms, nc_mask, six_axis_mode) is
// written through i_cfg_we / i_cfg_index / i_cfg_data; unknown indexes are ignored.
// Reset (i_rst_n low, synchronous) empties both registers, clears history and
// lockout state and loads the config defaults. While the receiver stalls, the
// result holds and one more scan can wait in the input register; after that
// o_in_stall rises until the result is taken.
module joystick_input_conditioner_core #(
    parameter int NUM_AXES     = 6,
    parameter int NUM_SWITCHES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  jic_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output jic_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [jic_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [jic_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                              r_in_valid;
    jic_pkg::t_in_word                 r_in_word;
    logic                              r_out_valid;
    jic_pkg::t_out_word                r_out_word;
    jic_pkg::t_out_word                n_out_word;
    logic [jic_pkg::DEBOUNCE_W-1:0]    r_debounce_ms;
    logic [jic_pkg::SWITCH_FIELDS-1:0] r_nc_mask;
    logic                              r_six_axis_mode;
    logic                              advance;
    logic                              load_in;
    jic_pkg::t_scan_ctl                ctl;

    logic [jic_pkg::AXIS_FIELDS-1:0][jic_pkg::AXIS_W-1:0] samples;
    logic [jic_pkg::AXIS_FIELDS-1:0][jic_pkg::AXIS_W-1:0] values;
    logic [jic_pkg::SWITCH_FIELDS-1:0]                    buttons;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign load_in     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign ctl.advance = advance;
    assign ctl.six     = r_six_axis_mode;

    assign samples[0] = r_in_word.sample_throttle;
    assign samples[1] = r_in_word.sample_propeller;
    assign samples[2] = r_in_word.sample_trim;
    assign samples[3] = r_in_word.sample_rudder;
    assign samples[4] = r_in_word.sample_x;
    assign samples[5] = r_in_word.sample_y;

    jic_axis_filter #(
        .NUM_AXES (NUM_AXES)
    ) u_axis (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_samples (samples),
        .o_values  (values)
    );

    jic_switch_debounce #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_switch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_levels      (r_in_word.switch_levels),
        .i_now_ms      (r_in_word.now_ms),
        .i_debounce_ms (r_debounce_ms),
        .i_nc_mask     (r_nc_mask),
        .o_buttons     (buttons)
    );

    always_comb begin
        n_out_word.out_throttle  = values[0];
        n_out_word.out_propeller = values[1];
        n_out_word.out_trim      = values[2];
        n_out_word.out_rudder    = values[3];
        n_out_word.out_x         = values[4];
        n_out_word.out_y         = values[5];
        n_out_word.button_word   = buttons;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= jic_pkg::DEBOUNCE_RESET;
            r_nc_mask       <= jic_pkg::NC_MASK_RESET;
            r_six_axis_mode <= jic_pkg::SIX_AXIS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jic_pkg::REG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data;
                jic_pkg::REG_NC_MASK:       r_nc_mask       <= i_cfg_data;
                jic_pkg::REG_SIX_AXIS_MODE: r_six_axis_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/jic_checker.sv]
// Port-level checks for the joystick input conditioner, bound to the top level.
module jic_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input jic_pkg::t_out_word o_out_word
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    // a stalled result word stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word dropped or changed");

    // the input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while result side is free");

    // once the receiver stops stalling, the input side is free in the same cycle
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled with receiver ready");

endmodule

bind joystick_input_conditioner_core jic_checker u_jic_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

[tb/sv/joystick_input_conditioner_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the joystick input conditioner core.
module joystick_input_conditioner_core_test;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;

    // index 3 is not decoded by the block
    localparam logic [jic_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [jic_pkg::AXIS_W-1:0]      AXIS_MAX   = '1;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    jic_pkg::t_in_word               i_in_word;
    logic                            o_out_valid;
    logic                            i_out_stall;
    jic_pkg::t_out_word              o_out_word;
    logic                            i_cfg_we;
    logic [jic_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [jic_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    joystick_input_conditioner_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // conditioner state as predicted
    logic [jic_pkg::DEBOUNCE_W-1:0]    cfg_debounce;
    logic [jic_pkg::SWITCH_FIELDS-1:0] cfg_nc_mask;
    logic                              cfg_six_axis;
    logic [jic_pkg::AXIS_W-1:0]        axis_history [jic_pkg::AXIS_FIELDS];
    logic [jic_pkg::SWITCH_FIELDS-1:0] debounced_levels;
    logic [jic_pkg::TIME_W-1:0]        lock_since [jic_pkg::SWITCH_FIELDS];

    jic_pkg::t_out_word expected_reports [$];
    int                 mismatch_count;
    int                 cycle_count;

    // traffic shaping
    logic                              idling_on;
    logic                              rx_hold_req;
    int                                tx_gap_pct;
    int                                rx_stall_pct;
    logic [jic_pkg::TIME_W-1:0]        scan_time;
    logic [jic_pkg::SWITCH_FIELDS-1:0] scan_levels;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic jic_pkg::t_out_word condition_scan(input jic_pkg::t_in_word w);
        jic_pkg::t_out_word         r;
        logic [jic_pkg::AXIS_W-1:0] fresh [jic_pkg::AXIS_FIELDS];
        logic [jic_pkg::AXIS_W-1:0] filtered [jic_pkg::AXIS_FIELDS];
        logic [jic_pkg::AXIS_W:0]   sum;
        logic [jic_pkg::AXIS_W-1:0] avg;
        logic [jic_pkg::TIME_W-1:0] elapsed;
        logic                       held;
        int                         active;
        int                         i;
        fresh[0] = w.sample_throttle;
        fresh[1] = w.sample_propeller;
        fresh[2] = w.sample_trim;
        fresh[3] = w.sample_rudder;
        fresh[4] = w.sample_x;
        fresh[5] = w.sample_y;
        active = cfg_six_axis ? jic_pkg::AXIS_FIELDS : jic_pkg::BASE_AXES;
        for (i = 0; i < jic_pkg::AXIS_FIELDS; i++) begin
            filtered[i] = '0;
            if (i < active) begin
                sum = {1'b0, fresh[i]} + {1'b0, axis_history[i]};
                avg = sum[jic_pkg::AXIS_W:1];
                axis_history[i] = fresh[i];
                filtered[i] = cfg_six_axis ? (AXIS_MAX - avg) : avg;
            end
        end
        r.out_throttle  = filtered[0];
        r.out_propeller = filtered[1];
        r.out_trim      = filtered[2];
        r.out_rudder    = filtered[3];
        r.out_x         = filtered[4];
        r.out_y         = filtered[5];
        r.button_word   = '0;
        // switches are only scanned in six-axis mode
        if (cfg_six_axis) begin
            for (i = 0; i < jic_pkg::SWITCH_FIELDS; i++) begin
                held = 1'b0;
                if (lock_since[i] != '0) begin
                    elapsed = w.now_ms - lock_since[i];
                    if (elapsed < {16'd0, cfg_debounce}) held = 1'b1;
                    else lock_since[i] = '0;
                end
                if (!held && debounced_levels[i] != w.switch_levels[i]) begin
                    debounced_levels[i] = w.switch_levels[i];
                    lock_since[i] = w.now_ms;
                end
            end
            r.button_word = debounced_levels ^ cfg_nc_mask;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // predict on every accepted scan word, check every accepted result word
    always @(posedge i_clk) begin
        jic_pkg::t_out_word want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                expected_reports.push_back(condition_scan(i_in_word));
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result word with nothing pending: %h", o_out_word);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("out_throttle", 16'(want.out_throttle),
                                16'(o_out_word.out_throttle));
                    check_field("out_propeller", 16'(want.out_propeller),
                                16'(o_out_word.out_propeller));
                    check_field("out_trim", 16'(want.out_trim), 16'(o_out_word.out_trim));
                    check_field("out_rudder", 16'(want.out_rudder),
                                16'(o_out_word.out_rudder));
                    check_field("out_x", 16'(want.out_x), 16'(o_out_word.out_x));
                    check_field("out_y", 16'(want.out_y), 16'(o_out_word.out_y));
                    check_field("button_word", want.button_word, o_out_word.button_word);
                end
            end
        end
    end

    // receiver: random stall bursts, or one long hold on request
    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    function automatic jic_pkg::t_in_word scan_of(
        input logic [jic_pkg::AXIS_W-1:0]        s0, s1, s2, s3, s4, s5,
        input logic [jic_pkg::SWITCH_FIELDS-1:0] levels,
        input logic [jic_pkg::TIME_W-1:0]        now);
        jic_pkg::t_in_word w;
        w.sample_throttle  = s0;
        w.sample_propeller = s1;
        w.sample_trim      = s2;
        w.sample_rudder    = s3;
        w.sample_x         = s4;
        w.sample_y         = s5;
        w.switch_levels    = levels;
        w.now_ms           = now;
        return w;
    endfunction

    function automatic logic [jic_pkg::AXIS_W-1:0] rand_sample();
        logic [31:0] raw;
        int unsigned pick;
        raw  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8) return '0;
        if (pick < 16) return AXIS_MAX;
        return raw[jic_pkg::AXIS_W-1:0];
    endfunction

    // holds the word until the block takes it; valid stays high on return
    task automatic send_scan(input jic_pkg::t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // block must be idle
    task automatic set_register(input logic [jic_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [jic_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            jic_pkg::REG_DEBOUNCE_MS:   cfg_debounce = data;
            jic_pkg::REG_NC_MASK:       cfg_nc_mask  = data;
            jic_pkg::REG_SIX_AXIS_MODE: cfg_six_axis = data[0];
            default: ;
        endcase
    endtask

    // mostly a plausible switch history with time moving forward, some noise
    task automatic run_scans(input int count, input int unsigned step_max);
        logic [31:0] flips;
        int unsigned pick;
        int          n;
        for (n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                if (idling_on && $urandom_range(0, 3) != 0) begin
                    tx_gap_pct   = 20;
                    rx_stall_pct = 15;
                end else begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                scan_time   = scan_time + $urandom_range(0, step_max);
                flips       = $urandom & $urandom & $urandom;
                scan_levels = scan_levels ^ flips[jic_pkg::SWITCH_FIELDS-1:0];
            end else if (pick < 88) begin
                scan_time   = '0;
                flips       = $urandom;
                scan_levels = flips[jic_pkg::SWITCH_FIELDS-1:0];
            end else begin
                scan_time   = $urandom;
                flips       = $urandom;
                scan_levels = flips[jic_pkg::SWITCH_FIELDS-1:0];
            end
            send_scan(scan_of(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                              rand_sample(), rand_sample(), scan_levels, scan_time));
            if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_reset_and_extremes();
        send_scan(scan_of(0, 0, 0, 0, 0, 0, 16'h0000, 32'd0));
        // change at time zero leaves no lockout behind
        send_scan(scan_of(1023, 1023, 1023, 1023, 1023, 1023, 16'hFFFF, 32'd0));
        send_scan(scan_of(1023, 1023, 1023, 1023, 1023, 1023, 16'h0000, 32'd1));
        send_scan(scan_of(1023, 0, 1023, 0, 1023, 0, 16'hFFFF, 32'd5));
        // elapsed equals debounce: lockout over
        send_scan(scan_of(0, 1023, 0, 1023, 0, 1023, 16'hFFFF, 32'd11));
        send_scan(scan_of(512, 511, 1, 1022, 341, 682, 16'h0000, 32'd20));
        send_scan(scan_of(682, 341, 1022, 1, 511, 512, 16'hA5A5, 32'd21));
        wait_drained();
    endtask

    task automatic test_lockout_wrap();
        send_scan(scan_of(1, 2, 4, 8, 16, 32, 16'h5A5A, 32'hFFFF_FFFA));
        // lockout spans the time wrap
        send_scan(scan_of(64, 128, 256, 512, 1023, 0, 16'h0000, 32'h0000_0002));
        send_scan(scan_of(0, 1023, 512, 256, 128, 64, 16'h0000, 32'h0000_0004));
        send_scan(scan_of(1022, 1021, 3, 5, 7, 9, 16'hFFFF, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    task automatic test_zero_debounce();
        set_register(jic_pkg::REG_DEBOUNCE_MS, 16'd0);
        send_scan(scan_of(100, 200, 300, 400, 500, 600, 16'h1234, 32'd100));
        send_scan(scan_of(700, 800, 900, 1000, 1023, 0, 16'hEDCB, 32'd100));
        send_scan(scan_of(0, 1023, 0, 1023, 0, 1023, 16'hFFFF, 32'd101));
        wait_drained();
    endtask

    task automatic test_register_writes();
        set_register(REG_UNUSED, 16'hFFFF);
        // only bit 0 of the mode register counts
        set_register(jic_pkg::REG_SIX_AXIS_MODE, 16'hFFFE);
        send_scan(scan_of(1023, 1023, 1023, 1023, 1023, 1023, 16'h0000, 32'd200));
        send_scan(scan_of(0, 1023, 0, 0, 1023, 0, 16'hFFFF, 32'd300));
        send_scan(scan_of(333, 666, 999, 1, 2, 3, 16'h0F0F, 32'd400));
        wait_drained();
        set_register(jic_pkg::REG_SIX_AXIS_MODE, 16'h0001);
        send_scan(scan_of(1023, 0, 1023, 0, 1023, 0, 16'hF0F0, 32'd401));
        send_scan(scan_of(0, 0, 0, 1023, 1023, 1023, 16'h0000, 32'd402));
        wait_drained();
    endtask

    task automatic test_default_random();
        set_register(jic_pkg::REG_DEBOUNCE_MS, jic_pkg::DEBOUNCE_RESET);
        set_register(jic_pkg::REG_NC_MASK, jic_pkg::NC_MASK_RESET);
        idling_on = 1'b1;
        run_scans(580, 6);
        wait_drained();
    endtask

    task automatic test_long_lockout();
        set_register(jic_pkg::REG_DEBOUNCE_MS, 16'hFFFF);
        set_register(jic_pkg::REG_NC_MASK, 16'hFFFF);
        run_scans(250, 30000);
        wait_drained();
    endtask

    task automatic test_no_lockout();
        set_register(jic_pkg::REG_DEBOUNCE_MS, 16'd0);
        set_register(jic_pkg::REG_NC_MASK, 16'h0000);
        run_scans(200, 3);
        wait_drained();
    endtask

    task automatic test_three_axis_random();
        logic [31:0] raw;
        raw = $urandom;
        set_register(jic_pkg::REG_DEBOUNCE_MS, 16'd37);
        set_register(jic_pkg::REG_NC_MASK, raw[15:0]);
        set_register(jic_pkg::REG_SIX_AXIS_MODE, 16'h0000);
        run_scans(200, 25);
        wait_drained();
        // switch state must have survived the three-axis stretch
        set_register(jic_pkg::REG_SIX_AXIS_MODE, 16'h0001);
        run_scans(200, 25);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        idling_on   = 1'b0;
        rx_hold_req = 1'b1;
        run_scans(40, 8);
        wait_drained();
        idling_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_scans(30, 10);
        wait_drained();
        run_scans(30, 10);
        wait_drained();
    endtask

    task automatic test_unthrottled();
        logic [31:0] raw;
        raw = $urandom;
        idling_on = 1'b0;
        set_register(jic_pkg::REG_DEBOUNCE_MS, 16'($urandom_range(1, 200)));
        set_register(jic_pkg::REG_NC_MASK, raw[31:16]);
        run_scans(300, 40);
    endtask

    initial begin
        int i;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cycle_count    = 0;
        mismatch_count = 0;
        cfg_debounce   = jic_pkg::DEBOUNCE_RESET;
        cfg_nc_mask    = jic_pkg::NC_MASK_RESET;
        cfg_six_axis   = jic_pkg::SIX_AXIS_RESET;
        for (i = 0; i < jic_pkg::AXIS_FIELDS; i++) axis_history[i] = '0;
        for (i = 0; i < jic_pkg::SWITCH_FIELDS; i++) lock_since[i] = '0;
        debounced_levels = '0;
        idling_on    = 1'b0;
        rx_hold_req  = 1'b0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        scan_time    = $urandom;
        scan_levels  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_extremes();
        test_lockout_wrap();
        test_zero_debounce();
        test_register_writes();
        test_default_random();
        test_long_lockout();
        test_no_lockout();
        test_three_axis_random();
        test_output_backpressure();
        test_sender_pause();
        test_unthrottled();
        wait_drained();

        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
